// ===== rtl/core/ebalu_pkg.sv =====
// Package with the shared types and constants of the eight-bit ALU core.
package ebalu_pkg;

	localparam int unsigned DataW = 8;
	localparam int unsigned StatusW = 6;
	localparam int unsigned CmdW = 4;

	localparam int unsigned FlagC = 0;
	localparam int unsigned FlagZ = 2;
	localparam int unsigned FlagOv = 3;
	localparam int unsigned FlagSle = 4;
	localparam int unsigned FlagSge = 5;

	typedef enum logic [CmdW-1:0] {
		CMD_ADD     = 4'd0,
		CMD_ADC     = 4'd1,
		CMD_SUB     = 4'd2,
		CMD_SUBB    = 4'd3,
		CMD_BCD_ADD = 4'd4,
		CMD_BCD_SUB = 4'd5,
		CMD_AND     = 4'd6,
		CMD_OR      = 4'd7,
		CMD_XOR     = 4'd8,
		CMD_COM     = 4'd9,
		CMD_INC     = 4'd10,
		CMD_DEC     = 4'd11,
		CMD_RRC     = 4'd12,
		CMD_RLC     = 4'd13,
		CMD_SWAP    = 4'd14
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [DataW-1:0]   operand_a;
		logic [DataW-1:0]   operand_b;
		logic [StatusW-1:0] status_in;
	} req_t;

	typedef struct packed {
		logic [DataW-1:0]   result;
		logic [StatusW-1:0] status_out;
	} rsp_t;

endpackage

// ===== rtl/core/ebalu_exec.sv =====
// Combinational datapath that computes the result and status of one operation.
module ebalu_exec (
	input  ebalu_pkg::req_t req,
	output ebalu_pkg::rsp_t rsp
);

	logic [7:0] a;
	logic [7:0] b;
	logic       c;
	logic       bw;
	logic [5:0] st;
	logic [8:0] sum9;
	logic [8:0] sb9;
	logic [8:0] diff9;
	logic       sub_c;
	logic [7:0] av;
	logic [7:0] bv;
	logic [7:0] bsb;
	logic [8:0] bcd_sum9;
	logic [8:0] bcd_diff9;
	logic [8:0] bcd_sel9;
	logic [6:0] mod100;
	logic [14:0] tens_prod;
	logic [3:0] tens;
	logic [6:0] ones_full;
	logic [7:0] r;

	assign a = req.operand_a;
	assign b = req.operand_b;
	assign c = req.status_in[ebalu_pkg::FlagC];
	assign bw = ~c;

	assign sum9 = {1'b0, a} + {1'b0, b} + {8'd0, (req.cmd == ebalu_pkg::CMD_ADC) & c};
	assign sb9 = {1'b0, b} + {8'd0, (req.cmd == ebalu_pkg::CMD_SUBB) & bw};
	assign diff9 = {1'b0, a} - sb9;
	assign sub_c = ({1'b0, a} >= sb9);

	// Packed digits weigh ten and one, even when a digit is above nine.
	assign av = {1'b0, a[7:4], 3'b000} + {3'b000, a[7:4], 1'b0} + {4'd0, a[3:0]};
	assign bv = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'd0, b[3:0]};
	assign bsb = bv + {7'd0, bw};
	assign bcd_sum9 = {1'b0, av} + {1'b0, bv} + {8'd0, c};
	assign bcd_diff9 = {1'b0, av} + 9'd200 - {1'b0, bsb};
	assign bcd_sel9 = (req.cmd == ebalu_pkg::CMD_BCD_ADD) ? bcd_sum9 : bcd_diff9;

	always_comb begin
		if (bcd_sel9 >= 9'd300) begin
			mod100 = 7'(bcd_sel9 - 9'd300);
		end else if (bcd_sel9 >= 9'd200) begin
			mod100 = 7'(bcd_sel9 - 9'd200);
		end else if (bcd_sel9 >= 9'd100) begin
			mod100 = 7'(bcd_sel9 - 9'd100);
		end else begin
			mod100 = bcd_sel9[6:0];
		end
	end

	// Division by ten through the reciprocal 205 / 2048, exact below 1029.
	assign tens_prod = {8'd0, mod100} * 15'd205;
	assign tens = tens_prod[14:11];
	assign ones_full = mod100 - ({3'd0, tens} * 7'd10);

	always_comb begin
		st = req.status_in;
		r = 8'd0;
		case (req.cmd)
			ebalu_pkg::CMD_ADD, ebalu_pkg::CMD_ADC: begin
				r = sum9[7:0];
				st[ebalu_pkg::FlagC] = sum9[8];
				st[ebalu_pkg::FlagOv] = (a[7] ^ r[7]) & (b[7] ^ r[7]);
				st[ebalu_pkg::FlagZ] = (r == 8'd0);
				st[ebalu_pkg::FlagSle] = ~r[7];
				st[ebalu_pkg::FlagSge] = r[7];
			end
			ebalu_pkg::CMD_SUB, ebalu_pkg::CMD_SUBB: begin
				r = diff9[7:0];
				st[ebalu_pkg::FlagC] = sub_c;
				st[ebalu_pkg::FlagOv] = (a[7] ^ b[7]) & (a[7] ^ r[7]);
				st[ebalu_pkg::FlagZ] = (r == 8'd0);
				st[ebalu_pkg::FlagSle] = ~r[7];
				st[ebalu_pkg::FlagSge] = r[7];
			end
			ebalu_pkg::CMD_BCD_ADD: begin
				r = {tens, ones_full[3:0]};
				st[ebalu_pkg::FlagC] = (bcd_sum9 > 9'd99);
			end
			ebalu_pkg::CMD_BCD_SUB: begin
				r = {tens, ones_full[3:0]};
				st[ebalu_pkg::FlagC] = (av >= bsb);
			end
			ebalu_pkg::CMD_AND: begin
				r = a & b;
				st[ebalu_pkg::FlagZ] = (r == 8'd0);
			end
			ebalu_pkg::CMD_OR: begin
				r = a | b;
				st[ebalu_pkg::FlagZ] = (r == 8'd0);
			end
			ebalu_pkg::CMD_XOR: begin
				r = a ^ b;
				st[ebalu_pkg::FlagZ] = (r == 8'd0);
			end
			ebalu_pkg::CMD_COM: begin
				r = ~a;
				st[ebalu_pkg::FlagZ] = (r == 8'd0);
			end
			ebalu_pkg::CMD_INC: begin
				r = a + 8'd1;
				st[ebalu_pkg::FlagC] = (a == 8'hFF);
				st[ebalu_pkg::FlagZ] = (r == 8'd0);
			end
			ebalu_pkg::CMD_DEC: begin
				r = a - 8'd1;
				st[ebalu_pkg::FlagC] = (a != 8'd0);
				st[ebalu_pkg::FlagZ] = (r == 8'd0);
			end
			ebalu_pkg::CMD_RRC: begin
				r = {c, a[7:1]};
				st[ebalu_pkg::FlagC] = a[0];
			end
			ebalu_pkg::CMD_RLC: begin
				r = {a[6:0], c};
				st[ebalu_pkg::FlagC] = a[7];
			end
			ebalu_pkg::CMD_SWAP: begin
				r = {a[3:0], a[7:4]};
			end
			default: begin
				r = 8'd0;
			end
		endcase
	end

	assign rsp.result = r;
	assign rsp.status_out = st;

endmodule

// ===== rtl/core/eight_bit_alu_with_bcd_and_flags_core.sv =====
// Top level of the eight-bit ALU core with an input register and a result register.
//
// Channel | Signals                    | Payload
// --------+----------------------------+-------------------------------------------
// req     | req_valid, req_ready, req  | cmd, operand_a, operand_b, status_in
// rsp     | rsp_valid, rsp_ready, rsp  | result, status_out
//
// A beat accepted on req is captured in the input register, passes the combinational datapath,
// and is then registered in the result register, which drives rsp.
// One beat is accepted every cycle while rsp is not stalled; the datapath between the registers is combinational.
// Reset clears both stage valid bits; the payload registers are not reset.
// A stall on rsp holds the result register and backs up into the input register.
module eight_bit_alu_with_bcd_and_flags_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ebalu_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ebalu_pkg::rsp_t rsp
);

	ebalu_pkg::req_t req_s1;
	logic            valid_s1;
	ebalu_pkg::rsp_t rsp_s2;
	logic            valid_s2;
	ebalu_pkg::rsp_t exec_rsp;
	logic            adv_s1;

	assign adv_s1 = ~valid_s2 | rsp_ready;
	assign req_ready = ~valid_s1 | adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (valid_s1 && adv_s1) begin
			rsp_s2 <= exec_rsp;
		end
	end

	ebalu_exec u_exec (
		.req (req_s1),
		.rsp (exec_rsp)
	);

	assign rsp_valid = valid_s2;
	assign rsp = rsp_s2;

	a_load_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> valid_s1)
		else $error("Accepted beat did not reach the input register.");

	a_move_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s1 |=> rsp_valid)
		else $error("Input register beat did not reach the result register.");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("Input held off while the result register is empty.");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(req_s1))
		else $error("Input register lost its beat during a stall.");

endmodule
